FILE: hw/rtl/dctc_pkg.sv
`default_nettype none
package dctc_pkg;

  localparam int NUM_BANKS           = 64;
  localparam int NUM_BANK_GROUPS     = 16;
  localparam int NUM_SIDS            = 4;
  localparam int NUM_PSEUDO_CHANNELS = 16;
  localparam int NUM_CHANNELS        = 8;
  localparam int MAX_CONSTRAINTS     = 64;

  localparam int HIST_DEPTH    = 4;
  localparam int NUM_CMDS      = 8;
  localparam int NUM_RESOURCES = NUM_BANKS + NUM_BANK_GROUPS + NUM_SIDS
                               + NUM_PSEUDO_CHANNELS + NUM_CHANNELS;
  localparam int ROW_W         = $clog2(NUM_RESOURCES);
  localparam int HIST_ENTRIES  = NUM_RESOURCES * NUM_CMDS;
  localparam int H_W           = ROW_W + 3;
  localparam int TIME_ENTRIES  = HIST_ENTRIES * HIST_DEPTH;
  localparam int TA_W          = H_W + 2;
  localparam int TBL_AW        = $clog2(MAX_CONSTRAINTS);
  localparam int CNT_W         = $clog2(MAX_CONSTRAINTS + 1);
  localparam int CFG_W         = 7;
  localparam int IN_W          = 104;
  localparam int OUT_W         = 72;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_QUERY  = 2'd1,
    OP_RECORD = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [2:0] CMD_PRE  = 3'd1;
  localparam logic [2:0] CMD_PREA = 3'd2;
  localparam logic [2:0] CMD_RD   = 3'd3;
  localparam logic [2:0] CMD_RDA  = 3'd4;
  localparam logic [2:0] CMD_WR   = 3'd5;
  localparam logic [2:0] CMD_WRA  = 3'd6;

  localparam logic [2:0] SC_BANK    = 3'd0;
  localparam logic [2:0] SC_BG      = 3'd1;
  localparam logic [2:0] SC_SID     = 3'd2;
  localparam logic [2:0] SC_PC      = 3'd3;
  localparam logic [2:0] SC_CHANNEL = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_QUERY,
    ST_REC_RD,
    ST_REC_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] time_req;
    logic [2:0]  channel;
    logic [3:0]  pseudo_channel;
    logic [1:0]  sid;
    logic [3:0]  bank_group;
    logic [5:0]  bank;
    logic [5:0]  slot;
    logic [2:0]  distance;
    logic [2:0]  scope;
    logic [2:0]  preceding;
    logic [2:0]  command;
    op_t         operation;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  following;
    logic [2:0]  preceding;
    logic [2:0]  scope;
    logic [2:0]  distance;
    logic [63:0] delay;
  } cons_t;

  typedef struct packed {
    logic [2:0] cnt;
    logic [1:0] wp;
  } meta_t;

  typedef struct packed {
    logic             ok;
    logic [ROW_W-1:0] row;
  } row_t;

  function automatic logic [2:0] fold_cmd(logic [2:0] c);
    logic [2:0] r;
    case (c)
      CMD_PREA: r = CMD_PRE;
      CMD_RDA:  r = CMD_RD;
      CMD_WRA:  r = CMD_WR;
      default:  r = c;
    endcase
    return r;
  endfunction

  function automatic row_t scope_row(logic [2:0] sc, in_item_t it);
    row_t r;
    r.ok  = 1'b0;
    r.row = '0;
    case (sc)
      SC_BANK: begin
        r.ok  = int'(it.bank) < NUM_BANKS;
        r.row = ROW_W'(int'(it.bank));
      end
      SC_BG: begin
        r.ok  = int'(it.bank_group) < NUM_BANK_GROUPS;
        r.row = ROW_W'(NUM_BANKS + int'(it.bank_group));
      end
      SC_SID: begin
        r.ok  = int'(it.sid) < NUM_SIDS;
        r.row = ROW_W'(NUM_BANKS + NUM_BANK_GROUPS + int'(it.sid));
      end
      SC_PC: begin
        r.ok  = int'(it.pseudo_channel) < NUM_PSEUDO_CHANNELS;
        r.row = ROW_W'(NUM_BANKS + NUM_BANK_GROUPS + NUM_SIDS + int'(it.pseudo_channel));
      end
      SC_CHANNEL: begin
        r.ok  = int'(it.channel) < NUM_CHANNELS;
        r.row = ROW_W'(NUM_BANKS + NUM_BANK_GROUPS + NUM_SIDS + NUM_PSEUDO_CHANNELS
                       + int'(it.channel));
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dctc_ram.sv
`default_nettype none
module dctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dctc_accum.sv
`default_nettype none
// Add / max unit: sum registered, then folded into the running max.
module dctc_accum (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        init,
  input  wire logic [63:0] init_val,
  input  wire logic        in_valid,
  input  wire logic [63:0] pt,
  input  wire logic [63:0] delay,
  output logic             busy,
  output logic [63:0]      earliest,
  output logic             ovf
);

  logic        sv_r;
  logic [64:0] sum_r;
  logic [63:0] earliest_r;
  logic        ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else begin
      sv_r <= in_valid;
    end
    sum_r <= {1'b0, pt} + {1'b0, delay};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r      <= 1'b0;
      earliest_r <= '0;
    end else if (init) begin
      ovf_r      <= 1'b0;
      earliest_r <= init_val;
    end else if (sv_r) begin
      if (sum_r[64]) begin
        ovf_r      <= 1'b1;
        earliest_r <= '1;
      end else if (sum_r[63:0] > earliest_r) begin
        earliest_r <= sum_r[63:0];
      end
    end
  end

  assign busy     = sv_r;
  assign earliest = earliest_r;
  assign ovf      = ovf_r;

endmodule
`default_nettype wire

FILE: hw/rtl/dram_command_timing_checker.sv
// Query: the scan reads the n active constraint slots, n being the constraint
//   count (capped at 64), one slot per cycle through a pipelined table /
//   history / add-max path.
// Throughput: one word at a time; the next word is taken once the current one
//   is finished, while its result may still wait in the output register.
// Reset (rst_n low, synchronous): count register cleared, then a sweep over all
//   864 history counters empties them before the first word is accepted.
`default_nettype none
module dram_command_timing_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // operation[1:0] command[4:2] preceding[7:5] scope[10:8] distance[13:11]
  // slot[19:14] bank[25:20] bank_group[29:26] sid[31:30] pseudo_channel[35:32]
  // channel[38:36] time_req[102:39], pad[103]
  input  wire logic [dctc_pkg::IN_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // earliest_time[63:0] overflow[64], pad[71:65]
  output logic      [dctc_pkg::OUT_W-1:0] out_tdata,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [dctc_pkg::CFG_W-1:0] cfg_data
);

  dctc_pkg::state_t state_r, state_nxt;
  dctc_pkg::in_item_t item_r;
  dctc_pkg::in_item_t in_item;
  logic [dctc_pkg::CFG_W-1:0] cfg_r;
  logic [dctc_pkg::CNT_W-1:0] scan_r;
  logic [dctc_pkg::CNT_W-1:0] scan_n;
  logic [dctc_pkg::H_W-1:0]   clr_r;
  logic [2:0]                 sc_r;

  // query pipeline
  logic                       v1_r, v2_r, v3_r;
  logic [dctc_pkg::H_W-1:0]   h2_r;
  logic [2:0]                 dist2_r;
  logic [63:0]                delay2_r, delay3_r;

  // record
  logic                       rec_ok_r;
  logic [dctc_pkg::H_W-1:0]   rec_h_r;

  logic                       out_tvalid_r;
  logic [dctc_pkg::OUT_W-1:0] out_tdata_r;

  // memories
  dctc_pkg::cons_t            tbl_q, tbl_wdata;
  logic                       tbl_we;
  logic [dctc_pkg::TBL_AW-1:0] tbl_raddr;
  dctc_pkg::meta_t            meta_q, meta_wdata;
  logic                       meta_we;
  logic [dctc_pkg::H_W-1:0]   meta_waddr, meta_raddr;
  logic [63:0]                times_q;
  logic                       times_we;
  logic [dctc_pkg::TA_W-1:0]  times_waddr, times_raddr;

  logic        accept;
  logic        acc_busy, acc_ovf;
  logic [63:0] acc_earliest;
  logic        scan_go, scan_end, out_load;

  dctc_pkg::row_t s1_row, rec_row;
  logic           s1_hit, s2_hit;
  logic [2:0]     s1_prec;

  assign in_item   = dctc_pkg::in_item_t'(in_tdata[dctc_pkg::IN_W-2:0]);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign scan_n = (int'(cfg_r) > dctc_pkg::MAX_CONSTRAINTS)
                ? dctc_pkg::CNT_W'(dctc_pkg::MAX_CONSTRAINTS)
                : dctc_pkg::CNT_W'(cfg_r);
  assign scan_go  = (state_r == dctc_pkg::ST_QUERY) && (scan_r < scan_n);
  assign scan_end = !scan_go && !v1_r && !v2_r && !v3_r && !acc_busy;
  assign out_load = !out_tvalid_r || out_tready;

  // stage 1: table word back, match against the query
  assign s1_row  = dctc_pkg::scope_row(tbl_q.scope, item_r);
  assign s1_prec = tbl_q.preceding;
  assign s1_hit  = v1_r
                && (tbl_q.following == dctc_pkg::fold_cmd(item_r.command))
                && (tbl_q.distance != 3'd0)
                && (int'(tbl_q.distance) <= dctc_pkg::HIST_DEPTH)
                && s1_row.ok;

  // stage 2: history counter back, pick the entry
  assign s2_hit = v2_r && (meta_q.cnt >= dist2_r);

  assign rec_row = dctc_pkg::scope_row(sc_r, item_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dctc_pkg::ST_CLEAR: begin
        if (int'(clr_r) == dctc_pkg::HIST_ENTRIES - 1) state_nxt = dctc_pkg::ST_IDLE;
      end
      dctc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_item.operation)
            dctc_pkg::OP_LOAD:   state_nxt = dctc_pkg::ST_LOAD;
            dctc_pkg::OP_QUERY:  state_nxt = dctc_pkg::ST_QUERY;
            dctc_pkg::OP_RECORD: state_nxt = dctc_pkg::ST_REC_RD;
            default:             state_nxt = dctc_pkg::ST_DONE;
          endcase
        end
      end
      dctc_pkg::ST_LOAD:   state_nxt = dctc_pkg::ST_DONE;
      dctc_pkg::ST_QUERY: begin
        if (scan_end) state_nxt = dctc_pkg::ST_DONE;
      end
      dctc_pkg::ST_REC_RD: state_nxt = dctc_pkg::ST_REC_WR;
      dctc_pkg::ST_REC_WR: begin
        state_nxt = (sc_r == dctc_pkg::SC_CHANNEL) ? dctc_pkg::ST_DONE
                                                   : dctc_pkg::ST_REC_RD;
      end
      dctc_pkg::ST_DONE: begin
        if (out_load) state_nxt = dctc_pkg::ST_IDLE;
      end
      default: state_nxt = dctc_pkg::ST_IDLE;
    endcase
  end

  // outputs / memory controls
  always_comb begin
    in_tready   = 1'b0;
    tbl_we      = 1'b0;
    tbl_wdata   = '{following: item_r.command, preceding: item_r.preceding,
                    scope: item_r.scope, distance: item_r.distance,
                    delay: item_r.time_req};
    tbl_raddr   = scan_r[dctc_pkg::TBL_AW-1:0];
    meta_we     = 1'b0;
    meta_waddr  = rec_h_r;
    meta_wdata  = '{cnt: (int'(meta_q.cnt) >= dctc_pkg::HIST_DEPTH)
                         ? meta_q.cnt : meta_q.cnt + 3'd1,
                    wp: meta_q.wp + 2'd1};
    meta_raddr  = {s1_row.row, s1_prec};
    times_we    = 1'b0;
    times_waddr = {rec_h_r, meta_q.wp};
    times_raddr = {h2_r, meta_q.wp - dist2_r[1:0]};
    case (state_r)
      dctc_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
      end
      dctc_pkg::ST_IDLE: in_tready = 1'b1;
      dctc_pkg::ST_LOAD: begin
        tbl_we = int'(item_r.slot) < dctc_pkg::MAX_CONSTRAINTS;
      end
      dctc_pkg::ST_REC_RD: begin
        meta_raddr = {rec_row.row, dctc_pkg::fold_cmd(item_r.command)};
      end
      dctc_pkg::ST_REC_WR: begin
        meta_we  = rec_ok_r;
        times_we = rec_ok_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dctc_pkg::ST_CLEAR;
      clr_r        <= '0;
      cfg_r        <= '0;
      out_tvalid_r <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      scan_r       <= '0;
      sc_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == dctc_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid) cfg_r <= cfg_data;
      if (state_r == dctc_pkg::ST_DONE && out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      v1_r <= scan_go;
      v2_r <= s1_hit;
      v3_r <= s2_hit;
      if (accept) begin
        scan_r <= '0;
        sc_r   <= '0;
      end else begin
        if (scan_go) scan_r <= scan_r + 1'b1;
        if (state_r == dctc_pkg::ST_REC_WR) sc_r <= sc_r + 3'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_item;
    h2_r     <= meta_raddr;
    dist2_r  <= tbl_q.distance;
    delay2_r <= tbl_q.delay;
    delay3_r <= delay2_r;
    rec_ok_r <= rec_row.ok;
    rec_h_r  <= {rec_row.row, dctc_pkg::fold_cmd(item_r.command)};
    if (state_r == dctc_pkg::ST_DONE && out_load) begin
      out_tdata_r <= {7'd0, acc_ovf, acc_earliest};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  dctc_ram #(.WIDTH($bits(dctc_pkg::cons_t)), .DEPTH(dctc_pkg::MAX_CONSTRAINTS)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (item_r.slot[dctc_pkg::TBL_AW-1:0]),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_q)
  );

  dctc_ram #(.WIDTH($bits(dctc_pkg::meta_t)), .DEPTH(dctc_pkg::HIST_ENTRIES)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_q)
  );

  dctc_ram #(.WIDTH(64), .DEPTH(dctc_pkg::TIME_ENTRIES)) u_times (
    .clk   (clk),
    .we    (times_we),
    .waddr (times_waddr),
    .wdata (item_r.time_req),
    .raddr (times_raddr),
    .rdata (times_q)
  );

  // running max; seeded with "now" for a query, zero for anything else
  dctc_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .init     (accept),
    .init_val ((in_item.operation == dctc_pkg::OP_QUERY) ? in_item.time_req : 64'd0),
    .in_valid (v3_r),
    .pt       (times_q),
    .delay    (delay3_r),
    .busy     (acc_busy),
    .earliest (acc_earliest),
    .ovf      (acc_ovf)
  );

endmodule
`default_nettype wire
